FILE: hdl/nps3d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3-D nearest point search block.
// No dependencies; imported by nearest_point_search_3d_top and the testbench.

package nps3d_pkg;

    // Fixed field widths of the stream payloads.
    localparam int OPC_W      = 2;
    localparam int EXCL_W     = 9;
    localparam int IDX_OUT_W  = 8;
    localparam int DIST_W     = 50;
    localparam int FLAG_W     = 3;
    localparam int OUT_DATA_W = 64;

    // Distance reported when no point was compared; it is above any real distance.
    localparam logic [DIST_W-1:0] NONE_DIST = 50'h3_0000_0000_0000;
    // Largest distance a compared point may report.
    localparam logic [DIST_W-1:0] DIST_MAX  = 50'h2_FFFF_FFFF_FFFF;

    // Operation carried in the input tuser.
    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

FILE: hdl/nearest_point_search_3d_top.sv
`timescale 1ns / 1ps
// Clear, append and no-op inputs go straight to the result state; a query first scans each stored
// point through the table read, difference, square, sum and best-compare registers, reading but
// not comparing the skipped entry. A new input is taken only in the idle state, after the previous
// item's result is loaded into the output register; that input transfer can share the edge of the
// result transfer. The single table read port sets the scan rate. Synchronous active-low reset
// zeroes the point count, the threshold and all valid flags; table contents stay. Uses nps3d_pkg.

module nearest_point_search_3d_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Threshold register write port.
    input  logic                        i_cfg_we,
    input  logic [nps3d_pkg::DIST_W-1:0] i_cfg_wdata,

    // Input stream.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0: target_x, target_y, target_z, exclude_index, zero pad.
    input  logic [((3*COORD_BITS+nps3d_pkg::EXCL_W+7)/8)*8-1:0] s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [nps3d_pkg::OPC_W-1:0] s_axis_tuser,

    // Result stream.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0: nearest_index, nearest_dist_sq, zero pad.
    output logic [nps3d_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: found, too_close, same_position.
    output logic [nps3d_pkg::FLAG_W-1:0] m_axis_tuser
);

    import nps3d_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > EXCL_W) ? CNT_W : EXCL_W;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam int ENT_W = 3 * COORD_BITS;

    // Control registers.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_addr;
    logic [DIST_W-1:0] r_min_dist;
    logic              r_rd_vld, r_df_vld, r_sq_vld, r_sm_vld;
    logic              r_found;
    logic              r_out_vld;

    // Payload registers.
    logic signed [COORD_BITS-1:0] r_tx, r_ty, r_tz;
    logic [EXCL_W-1:0]            r_excl;
    logic [ENT_W-1:0]             r_rd_data;
    logic [IDX_W-1:0]             r_rd_idx, r_df_idx, r_sq_idx, r_sm_idx;
    logic signed [DIF_W-1:0]      r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]              r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]            r_sm_dist;
    logic [DIST_W-1:0]            r_best;
    logic [IDX_W-1:0]             r_best_idx;
    logic [IDX_OUT_W-1:0]         r_out_idx;
    logic [DIST_W-1:0]            r_out_dist;
    logic [FLAG_W-1:0]            r_out_flags;

    // Point table, one entry per point as {z, y, x}.
    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    // Combinational signals.
    logic                         w_accept;
    logic                         w_issue;
    logic                         w_skip;
    logic                         w_busy;
    logic                         w_load;
    logic                         w_append_we;
    t_opcode                      w_op;
    logic signed [COORD_BITS-1:0] w_in_x, w_in_y, w_in_z;
    logic [EXCL_W-1:0]            w_in_excl;
    logic signed [COORD_BITS-1:0] w_px, w_py, w_pz;
    logic signed [DIF_W-1:0]      n_dx, n_dy, n_dz;
    logic signed [SQ_W-1:0]       n_sqx, n_sqy, n_sqz;
    logic [SUM_W-1:0]             n_sum;
    logic [DIST_W-1:0]            n_sm_dist;
    logic                         n_better;

    // Unpack the input payload.
    assign w_op      = t_opcode'(s_axis_tuser);
    assign w_in_x    = $signed(s_axis_tdata[COORD_BITS-1:0]);
    assign w_in_y    = $signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign w_in_z    = $signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign w_in_excl = s_axis_tdata[3*COORD_BITS+EXCL_W-1:3*COORD_BITS];

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_append_we = w_accept && (w_op == OP_APPEND) && (r_count != CNT_W'(TABLE_DEPTH));

    // Scan address generation; the excluded entry is read but not marked valid.
    assign w_issue = (r_state == ST_SCAN) && (r_addr != r_count);
    assign w_skip  = (CMP_W'(r_excl) == CMP_W'(r_addr));
    assign w_busy  = r_rd_vld || r_df_vld || r_sq_vld || r_sm_vld;

    // Sequencer: next state, input ready and output load.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (w_op == OP_QUERY) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (!w_issue && !w_busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table write on append and registered table read during a scan.
    always_ff @(posedge i_clk) begin
        if (w_append_we) begin
            mem[r_count[IDX_W-1:0]] <= {w_in_z, w_in_y, w_in_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
        end
    end

    // Stage one: coordinate differences.
    assign w_px = $signed(r_rd_data[COORD_BITS-1:0]);
    assign w_py = $signed(r_rd_data[2*COORD_BITS-1:COORD_BITS]);
    assign w_pz = $signed(r_rd_data[3*COORD_BITS-1:2*COORD_BITS]);
    assign n_dx = DIF_W'(w_px) - DIF_W'(r_tx);
    assign n_dy = DIF_W'(w_py) - DIF_W'(r_ty);
    assign n_dz = DIF_W'(w_pz) - DIF_W'(r_tz);

    // Stage two: squares of the signed differences.
    assign n_sqx = r_dx * r_dx;
    assign n_sqy = r_dy * r_dy;
    assign n_sqz = r_dz * r_dz;

    // Stage three: sum, clamped below the not-found distance.
    assign n_sum     = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
    assign n_sm_dist = (EXT_W'(n_sum) >= EXT_W'(NONE_DIST)) ? DIST_MAX : DIST_W'(n_sum);

    // Stage four: keep the first strictly nearer point.
    assign n_better = !r_found || (r_sm_dist < r_best);

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx   <= w_in_x;
            r_ty   <= w_in_y;
            r_tz   <= w_in_z;
            r_excl <= w_in_excl;
        end
        r_rd_idx  <= r_addr[IDX_W-1:0];
        r_df_idx  <= r_rd_idx;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dz      <= n_dz;
        r_sq_idx  <= r_df_idx;
        r_sqx     <= $unsigned(n_sqx);
        r_sqy     <= $unsigned(n_sqy);
        r_sqz     <= $unsigned(n_sqz);
        r_sm_idx  <= r_sq_idx;
        r_sm_dist <= n_sm_dist;
    end

    // Control: count, address, valids, best tracking and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_addr     <= '0;
            r_min_dist <= '0;
            r_rd_vld   <= 1'b0;
            r_df_vld   <= 1'b0;
            r_sq_vld   <= 1'b0;
            r_sm_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_best     <= NONE_DIST;
            r_best_idx <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_dist <= i_cfg_wdata;
            end

            if (w_accept) begin
                unique case (w_op)
                    OP_CLEAR:  r_count <= '0;
                    OP_APPEND: begin
                        if (w_append_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    OP_QUERY:  r_addr <= '0;
                    default:   ;
                endcase
                r_found    <= 1'b0;
                r_best     <= NONE_DIST;
                r_best_idx <= '0;
            end

            if (w_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end

            r_rd_vld <= w_issue && !w_skip;
            r_df_vld <= r_rd_vld;
            r_sq_vld <= r_df_vld;
            r_sm_vld <= r_sq_vld;

            if (r_sm_vld) begin
                r_found <= 1'b1;
                if (n_better) begin
                    r_best     <= r_sm_dist;
                    r_best_idx <= r_sm_idx;
                end
            end

            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload, captured when the output register is free or draining.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx   <= IDX_OUT_W'(r_best_idx);
            r_out_dist  <= r_best;
            r_out_flags <= {r_found && (r_best == '0),
                            r_found && (r_best < r_min_dist),
                            r_found};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_dist, r_out_idx});
    assign m_axis_tuser  = r_out_flags;

`ifndef SYNTHESIS
    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("point count above table depth");

    // The scan address never runs past the fill count.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_count))
        else $error("scan address past point count");

    // The compare pipeline is empty whenever a new item can be taken.
    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy)
        else $error("scan pipeline busy in idle");

    // A result is only loaded into a free or draining output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_vld || m_axis_tready))
        else $error("result overwrote a pending transfer");

    // A found point always has a distance below the not-found value.
    a_found_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best != NONE_DIST))
        else $error("found point with not-found distance");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_point_search_3d_top: streams clears, appends and
// queries with random gaps and checks every result against a behavioral nearest search.
// Depends on nps3d_pkg and nearest_point_search_3d_top.

module testbench;
    import nps3d_pkg::*;

    localparam int COORD_W      = 24;
    localparam int TABLE_SIZE   = 256;
    localparam int IN_DATA_W    = ((3*COORD_W+EXCL_W+7)/8)*8;
    localparam int STALL_LIMIT  = 8000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [EXCL_W-1:0] NO_SKIP = EXCL_W'(TABLE_SIZE);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct {
        logic [IDX_OUT_W-1:0] index;
        logic [DIST_W-1:0]    dist_sq;
        logic                 found;
        logic                 too_close;
        logic                 same_pos;
    } t_nearest;

    // Mirror of the point table plus the queue of nearest-point answers still to arrive.
    class nearest_scoreboard;
        t_point            stored[TABLE_SIZE];
        int                n_points;
        logic [DIST_W-1:0] threshold;
        t_nearest          nearest_q[$];
        int                errors;
        int                n_inputs;
        int                n_results;
        int                n_found;
        int                n_close;
        int                n_same;

        function new();
            foreach (stored[i]) stored[i] = '{default: '0};
            n_points  = 0;
            threshold = '0;
            errors    = 0;
            n_inputs  = 0;
            n_results = 0;
            n_found   = 0;
            n_close   = 0;
            n_same    = 0;
        endfunction

        function int pending();
            return nearest_q.size();
        endfunction

        // Applies one accepted input transfer and queues the answer it must produce.
        function void note_input(t_opcode op, t_point p, logic [EXCL_W-1:0] skip);
            t_nearest r;
            longint   dx;
            longint   dy;
            longint   dz;
            longint   d;
            longint   best;
            int       i;
            r        = '{default: '0};
            best     = longint'(NONE_DIST);
            n_inputs++;
            case (op)
                OP_CLEAR: begin
                    n_points = 0;
                end
                OP_APPEND: begin
                    // A full table silently drops the point.
                    if (n_points < TABLE_SIZE) begin
                        stored[n_points] = p;
                        n_points++;
                    end
                end
                OP_QUERY: begin
                    for (i = 0; i < n_points; i++) begin
                        if (i == skip) continue;
                        dx = longint'(p.x) - longint'(stored[i].x);
                        dy = longint'(p.y) - longint'(stored[i].y);
                        dz = longint'(p.z) - longint'(stored[i].z);
                        d  = dx*dx + dy*dy + dz*dz;
                        if (d >= longint'(NONE_DIST)) d = longint'(NONE_DIST) - 1;
                        // Strict compare keeps the earliest index on a tie.
                        if (!r.found || d < best) begin
                            best    = d;
                            r.index = IDX_OUT_W'(i);
                        end
                        r.found = 1'b1;
                    end
                end
                default: ;
            endcase
            r.dist_sq   = best[DIST_W-1:0];
            r.too_close = r.found && (r.dist_sq < threshold);
            r.same_pos  = r.found && (r.dist_sq == '0);
            nearest_q.insert(nearest_q.size(), r);
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // Compares one result transfer with the oldest queued answer.
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [FLAG_W-1:0] flags);
            t_nearest want;
            t_nearest got;
            got.index     = data[IDX_OUT_W-1:0];
            got.dist_sq   = data[IDX_OUT_W +: DIST_W];
            got.found     = flags[0];
            got.too_close = flags[1];
            got.same_pos  = flags[2];
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d dist %0d",
                         $time, got.index, got.dist_sq);
                errors++;
                return;
            end
            want = nearest_q.pop_front();
            n_results++;
            n_found += want.found;
            n_close += want.too_close;
            n_same  += want.same_pos;
            compare_field("nearest_index", want.index, got.index);
            compare_field("nearest_dist_sq", want.dist_sq, got.dist_sq);
            compare_field("found", want.found, got.found);
            compare_field("too_close", want.too_close, got.too_close);
            compare_field("same_position", want.same_pos, got.same_pos);
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [DIST_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OPC_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [FLAG_W-1:0]     m_axis_tuser;

    nearest_scoreboard sb;
    int send_idle_pct = 32;
    int recv_idle_pct = 64;
    int stim_items    = 0;
    int stim_count    = 0;
    bit hold_request  = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    nearest_point_search_3d_top #(
        .TABLE_DEPTH(TABLE_SIZE),
        .COORD_BITS (COORD_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: threshold writes, input transfers and result transfers, sampled at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.threshold = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_input(t_opcode'(s_axis_tuser),
                              '{s_axis_tdata[0 +: COORD_W], s_axis_tdata[COORD_W +: COORD_W],
                                s_axis_tdata[2*COORD_W +: COORD_W]},
                              s_axis_tdata[3*COORD_W +: EXCL_W]);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            m_axis_tready <= 1'b0;
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_point point_at(int x, int y, int z);
        return '{COORD_W'(x), COORD_W'(y), COORD_W'(z)};
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c,
                                                              int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2*spread)) - spread;
        if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
        if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    // A negative spread draws each coordinate over the whole range.
    function automatic t_point random_point(t_point center, int spread);
        t_point p;
        if (spread < 0) begin
            p.x = COORD_W'($urandom);
            p.y = COORD_W'($urandom);
            p.z = COORD_W'($urandom);
        end else begin
            p.x = near_coord(center.x, spread);
            p.y = near_coord(center.y, spread);
            p.z = near_coord(center.z, spread);
        end
        return p;
    endfunction

    // Skip index: none, a stored entry, or an index at or past the count.
    function automatic logic [EXCL_W-1:0] pick_skip();
        case ($urandom_range(0, 4))
            0, 1:    return NO_SKIP;
            2, 3:    return (stim_count > 0) ? EXCL_W'($urandom_range(0, stim_count - 1))
                                             : NO_SKIP;
            default: return EXCL_W'($urandom_range(stim_count, TABLE_SIZE));
        endcase
    endfunction

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(t_opcode op, t_point p, logic [EXCL_W-1:0] skip);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({skip, p.z, p.y, p.x});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        stim_items++;
        if (op == OP_CLEAR) stim_count = 0;
        else if (op == OP_APPEND && stim_count < TABLE_SIZE) stim_count++;
    endtask

    task automatic write_threshold(logic [DIST_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stops offering and waits until every queued answer has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Extremes, ties, empty and fully excluded scans, threshold boundary (threshold is 2).
    task automatic run_directed();
        t_point lo;
        t_point hi;
        t_point origin;
        lo     = '{COORD_MIN, COORD_MIN, COORD_MIN};
        hi     = '{COORD_MAX, COORD_MAX, COORD_MAX};
        origin = point_at(0, 0, 0);
        send_item(OP_QUERY, origin, NO_SKIP);
        send_item(OP_NOP, hi, EXCL_W'(255));
        send_item(OP_APPEND, hi, NO_SKIP);
        send_item(OP_APPEND, lo, NO_SKIP);
        send_item(OP_QUERY, lo, NO_SKIP);
        // Largest possible distance, corner to corner.
        send_item(OP_QUERY, hi, EXCL_W'(0));
        send_item(OP_QUERY, lo, EXCL_W'(1));
        // Duplicate point: the tie must keep the earlier index.
        send_item(OP_APPEND, lo, NO_SKIP);
        send_item(OP_QUERY, lo, NO_SKIP);
        send_item(OP_QUERY, origin, EXCL_W'(255));
        send_item(OP_CLEAR, hi, NO_SKIP);
        send_item(OP_QUERY, lo, NO_SKIP);
        send_item(OP_APPEND, origin, NO_SKIP);
        // The only stored point is skipped.
        send_item(OP_QUERY, hi, EXCL_W'(0));
        send_item(OP_QUERY, point_at(1, 0, 0), NO_SKIP);
        send_item(OP_QUERY, point_at(1, 1, 0), NO_SKIP);
        send_item(OP_APPEND, point_at(-1, 1, -2), NO_SKIP);
        send_item(OP_QUERY, point_at(-1, 1, -2), EXCL_W'(0));
        send_item(OP_QUERY, point_at(5, -7, 3), EXCL_W'(1));
        send_item(OP_NOP, point_at(-1, -1, -1), NO_SKIP);
    endtask

    // One random sequence: mostly clear, a few appends and queries; sometimes noise.
    task automatic run_episode();
        t_point center;
        t_point p;
        t_point kept[$];
        int     spread;
        int     sel;
        center = random_point(center, -1);
        if ($urandom_range(0, 99) < 15) begin
            send_item(t_opcode'($urandom_range(0, 3)), random_point(center, -1),
                      EXCL_W'($urandom_range(0, TABLE_SIZE)));
            return;
        end
        case ($urandom_range(0, 3))
            0:       spread = -1;
            1:       spread = 4;
            2:       spread = 200;
            default: spread = 5000;
        endcase
        if ($urandom_range(0, 3) != 0) begin
            send_item(OP_CLEAR, random_point(center, -1), EXCL_W'($urandom_range(0, TABLE_SIZE)));
        end
        repeat ($urandom_range(0, 8)) begin
            if (kept.size() > 0 && $urandom_range(0, 4) == 0) p = kept[$];
            else p = random_point(center, spread);
            kept.insert(kept.size(), p);
            send_item(OP_APPEND, p, EXCL_W'($urandom_range(0, TABLE_SIZE)));
        end
        repeat ($urandom_range(1, 4)) begin
            sel = $urandom_range(0, 9);
            if (kept.size() > 0 && sel < 3) p = kept[$urandom_range(0, kept.size() - 1)];
            else if (sel < 8) p = random_point(center, spread);
            else p = random_point(center, -1);
            send_item(OP_QUERY, p, pick_skip());
        end
    endtask

    task automatic run_random(int n_items);
        int start;
        start = stim_items;
        while (stim_items - start < n_items) run_episode();
    endtask

    // Fills the whole table, pushes two appends past capacity, then queries it.
    task automatic fill_table();
        t_point center;
        t_point first_pt;
        t_point p;
        center = random_point(center, -1);
        send_item(OP_CLEAR, center, NO_SKIP);
        for (int i = 0; i < TABLE_SIZE + 2; i++) begin
            p = ($urandom_range(0, 1) == 0) ? random_point(center, -1)
                                             : random_point(center, 3000);
            if (i == 0) first_pt = p;
            send_item(OP_APPEND, p, NO_SKIP);
        end
        send_item(OP_QUERY, first_pt, NO_SKIP);
        send_item(OP_QUERY, first_pt, EXCL_W'(0));
        send_item(OP_QUERY, center, EXCL_W'(255));
        send_item(OP_QUERY, random_point(center, -1), pick_skip());
    endtask

    // Main sequence: reset, directed items, then four random phases with new thresholds.
    initial begin
        logic [63:0] thr64;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_threshold(DIST_W'(2));
        run_directed();
        wait_for_results();

        write_threshold('0);
        run_random(40);
        wait_for_results();

        send_idle_pct = 64;
        recv_idle_pct = 32;
        write_threshold(NONE_DIST);
        run_random(40);
        wait_for_results();

        // No idling from here on; the long result hold-off lands on the table fill.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        thr64 = {$urandom, $urandom};
        thr64 = thr64 % (64'(NONE_DIST) + 64'd1);
        write_threshold(thr64[DIST_W-1:0]);
        hold_request = 1'b1;
        fill_table();
        run_random(40);
        wait_for_results();

        write_threshold(DIST_W'($urandom_range(0, 1 << 24)));
        run_random(40);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run summary: %0d input transfers, %0d results checked, %0d found a point,",
                 sb.n_inputs, sb.n_results, sb.n_found);
        $display("  %0d under the threshold, %0d at the target; table overflow and ties included.",
                 sb.n_close, sb.n_same);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
